[rtl/cave_automaton_step_assert.svh]
// Assertion macros for the cave automaton step block.
// Used by the top level; expects signals clk and rst_n in scope.
`ifndef CAVE_AUTOMATON_STEP_ASSERT_SVH
`define CAVE_AUTOMATON_STEP_ASSERT_SVH

// Check a consequence in the same cycle as its trigger
`define CAVE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its trigger
`define CAVE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/cave_pkg.sv]
// Shared types and constants for the cave automaton step block.
// No dependencies; used by the queue, front, back and top-level files of the block.
package cave_pkg;

  // Size limits of the line stores and frame
  localparam int CAVE_MAX_WIDTH  = 1024;
  localparam int CAVE_MAX_HEIGHT = 1024;

  // Register field widths
  localparam int SIZE_W     = 11;
  localparam int THR_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int CNT_W      = 4;

  // Queue between front and back
  localparam int FIFO_DEPTH = 4;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_SURVIVE      = 2'd2,
    REG_BIRTH        = 2'd3
  } cave_reg_t;

  // Reset values of the registers
  localparam logic [SIZE_W-1:0] RST_FRAME_WIDTH  = 11'd64;
  localparam logic [SIZE_W-1:0] RST_FRAME_HEIGHT = 11'd64;
  localparam logic [THR_W-1:0]  RST_SURVIVE      = 4'd4;
  localparam logic [THR_W-1:0]  RST_BIRTH        = 4'd5;

  typedef struct packed {
    logic [SIZE_W-1:0] frame_width;
    logic [SIZE_W-1:0] frame_height;
    logic [THR_W-1:0]  survive_threshold;
    logic [THR_W-1:0]  birth_threshold;
  } cave_cfg_t;

  // One classified column: cells bottom to top are col[2:0] = {cur, mid, top}
  typedef struct packed {
    logic [2:0] col;
    logic       first;
    logic       emit;
    logic       last;
    logic       restart;
  } cave_col_t;

  // Queue fill status seen by the front
  typedef struct packed {
    logic room_one;
    logic room_two;
  } cave_fifo_stat_t;

endpackage

[rtl/cave_in_if.sv]
// Input channel of the cave automaton step block: one cell or drain item.
// Standalone interface, no dependencies.
interface cave_in_if;
  logic valid;
  logic ready;
  logic kind;
  logic cell_in;

  modport source (output valid, output kind, output cell_in, input ready);
  modport sink   (input valid, input kind, input cell_in, output ready);
endinterface

[rtl/cave_out_if.sv]
// Result channel of the cave automaton step block: one next-generation cell.
// Standalone interface, no dependencies.
interface cave_out_if;
  logic valid;
  logic ready;
  logic cell_out;
  logic last_out;

  modport source (output valid, output cell_out, output last_out, input ready);
  modport sink   (input valid, input cell_out, input last_out, output ready);
endinterface

[rtl/cave_fifo.sv]
// Short queue of classified columns between front and back.
// Depends on cave_pkg.
module cave_fifo (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  cave_pkg::cave_col_t        push_data,
  input  logic                       pop,
  output logic                       head_valid,
  output cave_pkg::cave_col_t        head,
  output cave_pkg::cave_fifo_stat_t  stat
);
  localparam int PTR_W = $clog2(cave_pkg::FIFO_DEPTH);
  localparam int LVL_W = $clog2(cave_pkg::FIFO_DEPTH + 1);

  cave_pkg::cave_col_t entry_r [cave_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [LVL_W-1:0] level_r, level_nxt;

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and level
  always_comb begin
    level_nxt = level_r;
    if (push && !pop) begin
      level_nxt = level_r + LVL_W'(1);
    end else if (!push && pop) begin
      level_nxt = level_r - LVL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      level_r <= level_nxt;
    end
  end

  assign head_valid    = (level_r != '0);
  assign head          = entry_r[rd_ptr_r];
  assign stat.room_one = (level_r < LVL_W'(cave_pkg::FIFO_DEPTH));
  assign stat.room_two = (level_r < LVL_W'(cave_pkg::FIFO_DEPTH - 1));
endmodule

[rtl/cave_front.sv]
// Front of the cave automaton step: accepts items, tracks raster position,
// keeps the two line stores and builds one classified column per item. Uses cave_pkg.
module cave_front #(
  parameter int MAX_WIDTH  = cave_pkg::CAVE_MAX_WIDTH,
  parameter int MAX_HEIGHT = cave_pkg::CAVE_MAX_HEIGHT
) (
  input  logic                      clk,
  input  logic                      rst_n,
  cave_in_if.sink                   in_s,
  input  cave_pkg::cave_cfg_t       cfg,
  input  cave_pkg::cave_fifo_stat_t fifo_stat,
  output logic                      push_valid,
  output cave_pkg::cave_col_t       push_data
);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WSZ_W  = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);
  localparam int WCMP_W = (WSZ_W > cave_pkg::SIZE_W) ? WSZ_W : cave_pkg::SIZE_W;
  localparam int HCMP_W = (ROW_W > cave_pkg::SIZE_W) ? ROW_W : cave_pkg::SIZE_W;

  // Position of the next input item
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  // Clearing pass after reset
  logic             clr_busy_r;
  logic [COL_W-1:0] clr_addr_r;

  // Second stage: line store data comes back
  logic             b_valid_r;
  logic [COL_W-1:0] b_addr_r;
  logic             b_cur_r, b_mtop_r, b_mmid_r;
  logic             b_first_r, b_emit_r, b_last_r, b_restart_r;

  logic [1:0]       line_mem [MAX_WIDTH];
  logic [1:0]       rd_r;

  logic [WSZ_W-1:0] w_eff;
  logic [ROW_W-1:0] h_eff, h_p1;
  logic             accept, at_start, cur, emit, last, restart;
  logic             top_b, mid_b;
  logic             wr_en;
  logic [COL_W-1:0] wr_addr;
  logic [1:0]       wr_data;

  // Clamp frame size to the supported range
  always_comb begin
    if (cfg.frame_width == '0) begin
      w_eff = WSZ_W'(1);
    end else if (WCMP_W'(cfg.frame_width) > WCMP_W'(MAX_WIDTH)) begin
      w_eff = WSZ_W'(MAX_WIDTH);
    end else begin
      w_eff = WSZ_W'(cfg.frame_width);
    end
    if (cfg.frame_height == '0) begin
      h_eff = ROW_W'(1);
    end else if (HCMP_W'(cfg.frame_height) > HCMP_W'(MAX_HEIGHT)) begin
      h_eff = ROW_W'(MAX_HEIGHT);
    end else begin
      h_eff = ROW_W'(cfg.frame_height);
    end
    h_p1 = h_eff + ROW_W'(1);
  end

  // Classify the item at the current position
  always_comb begin
    accept   = in_s.valid && in_s.ready;
    at_start = (col_r == '0);
    cur      = !in_s.kind && (row_r < h_eff) && in_s.cell_in;
    if (at_start) begin
      emit = (row_r > ROW_W'(1)) && (row_r <= h_p1);
    end else begin
      emit = (row_r != '0) && (row_r <= h_eff);
    end
    last    = at_start && (row_r == h_p1);
    restart = at_start && (row_r > h_eff);
  end

  // Advance the raster position
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (restart) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (WSZ_W'(col_r) >= w_eff - WSZ_W'(1)) begin
        col_nxt = '0;
        row_nxt = row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  assign in_s.ready = !clr_busy_r && (b_valid_r ? fifo_stat.room_two : fifo_stat.room_one);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      b_valid_r  <= 1'b0;
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      b_valid_r <= accept;
      if (clr_busy_r) begin
        if (clr_addr_r == COL_W'(MAX_WIDTH - 1)) begin
          clr_busy_r <= 1'b0;
        end
        clr_addr_r <= clr_addr_r + COL_W'(1);
      end
    end
  end

  // Hold item details for the second stage
  always_ff @(posedge clk) begin
    if (accept) begin
      b_addr_r    <= col_r;
      b_cur_r     <= cur;
      b_mtop_r    <= (row_r > ROW_W'(1));
      b_mmid_r    <= (row_r != '0);
      b_first_r   <= at_start;
      b_emit_r    <= emit;
      b_last_r    <= last;
      b_restart_r <= restart;
    end
  end

  // Mask rows above the frame top and shift the column down one line
  assign top_b   = b_mtop_r & rd_r[1];
  assign mid_b   = b_mmid_r & rd_r[0];
  assign wr_en   = clr_busy_r || b_valid_r;
  assign wr_addr = clr_busy_r ? clr_addr_r : b_addr_r;
  assign wr_data = clr_busy_r ? 2'b00 : {mid_b, b_cur_r};

  // Line stores: bit 1 two rows up, bit 0 one row up
  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[wr_addr] <= wr_data;
    end
  end

  // Read with write-through for a same-address write in this cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      if (wr_en && (wr_addr == col_r)) begin
        rd_r <= wr_data;
      end else begin
        rd_r <= line_mem[col_r];
      end
    end
  end

  assign push_valid        = b_valid_r;
  assign push_data.col     = {b_cur_r, mid_b, top_b};
  assign push_data.first   = b_first_r;
  assign push_data.emit    = b_emit_r;
  assign push_data.last    = b_last_r;
  assign push_data.restart = b_restart_r;
endmodule

[rtl/cave_back.sv]
// Back of the cave automaton step: slides the 3x3 window, applies the
// survive/birth rule and holds the result register. Uses cave_pkg.
module cave_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  cave_pkg::cave_col_t head,
  input  cave_pkg::cave_cfg_t cfg,
  output logic                pop,
  cave_out_if.source          out_s
);
  logic [8:0] window_r, window_nxt;
  logic [8:0] shifted;
  logic [cave_pkg::CNT_W-1:0] n_live;
  logic       alive;
  logic       out_valid_r, cell_r, last_r;

  // Slide the window and count the eight neighbours
  always_comb begin
    shifted = {3'b000, window_r[8:3]};
    if (!head.first) begin
      shifted[8:6] = head.col;
    end
    n_live = '0;
    for (int i = 0; i < 9; i++) begin
      if (i != 4) begin
        n_live = n_live + cave_pkg::CNT_W'(shifted[i]);
      end
    end
    if (shifted[4]) begin
      alive = (n_live >= cfg.survive_threshold);
    end else begin
      alive = (n_live >= cfg.birth_threshold);
    end
    if (head.first) begin
      window_nxt = head.restart ? 9'd0 : {head.col, 6'd0};
    end else begin
      window_nxt = shifted;
    end
  end

  // Take the head when it needs no output slot or the slot frees up
  assign pop = head_valid && (!head.emit || !out_valid_r || out_s.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        window_r <= window_nxt;
      end
      if (pop && head.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_s.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (pop && head.emit) begin
      cell_r <= alive;
      last_r <= head.last;
    end
  end

  assign out_s.valid    = out_valid_r;
  assign out_s.cell_out = cell_r;
  assign out_s.last_out = last_r;
endmodule

[rtl/cave_automaton_step.sv]
// One generation of the cave cellular automaton over a raster-ordered frame.
// After reset every line store entry is cleared, during which
// in_s.ready stays low; configuration writes are taken throughout. Then one
// cell is accepted per cycle and one result is given per cycle while the queue
// has room and out_s is ready; the line store reads one entry and writes one
// entry per item. A result passes the front's second stage, the column queue
// and the result register on its way to out_s. Results lag the frame by
// frame_width + 1 items: send that many drain items after the last cell to
// flush the frame. last_out marks the frame's final cell.
module cave_automaton_step #(
  parameter int MAX_WIDTH  = cave_pkg::CAVE_MAX_WIDTH,
  parameter int MAX_HEIGHT = cave_pkg::CAVE_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  cave_in_if.sink                         in_s,
  cave_out_if.source                      out_s,
  input  logic                            cfg_we,
  input  logic [cave_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [cave_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  `include "cave_automaton_step_assert.svh"

  cave_pkg::cave_cfg_t       cfg_r, cfg_nxt;
  cave_pkg::cave_fifo_stat_t fifo_stat;
  cave_pkg::cave_col_t       push_data, head;
  logic                      push_valid, head_valid, pop;

  // Register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cave_pkg::cave_reg_t'(cfg_addr))
        cave_pkg::REG_FRAME_WIDTH:  cfg_nxt.frame_width  = cfg_wdata;
        cave_pkg::REG_FRAME_HEIGHT: cfg_nxt.frame_height = cfg_wdata;
        cave_pkg::REG_SURVIVE:
          cfg_nxt.survive_threshold = cfg_wdata[cave_pkg::THR_W-1:0];
        cave_pkg::REG_BIRTH:
          cfg_nxt.birth_threshold = cfg_wdata[cave_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width       <= cave_pkg::RST_FRAME_WIDTH;
      cfg_r.frame_height      <= cave_pkg::RST_FRAME_HEIGHT;
      cfg_r.survive_threshold <= cave_pkg::RST_SURVIVE;
      cfg_r.birth_threshold   <= cave_pkg::RST_BIRTH;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  cave_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_s       (in_s),
    .cfg        (cfg_r),
    .fifo_stat  (fifo_stat),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  cave_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push_valid),
    .push_data  (push_data),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .stat       (fifo_stat)
  );

  cave_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .cfg        (cfg_r),
    .pop        (pop),
    .out_s      (out_s)
  );

  // Every accepted item reaches the queue in the next cycle
  `CAVE_ASSERT_NEXT(a_accept_push, in_s.valid && in_s.ready, push_valid, "accepted item not queued")
  // The queue never takes an entry while full unless it pops in the same cycle
  `CAVE_ASSERT_SAME(a_no_overflow, push_valid && !pop, fifo_stat.room_one, "column queue overflow")
  // A result is never loaded over one that is still waiting
  `CAVE_ASSERT_SAME(a_no_overwrite, out_s.valid && !out_s.ready, !(pop && head.emit), "pending result overwritten")
endmodule

[test/testbench.sv]
// Testbench for cave_automaton_step: directed table, a tall one-column frame, a single-row frame,
// then random frames with random settings. Needs cave_pkg and the cave_in_if / cave_out_if
// interfaces; results are checked against a cycle-free model of one automaton generation kept in this file.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cave_pkg::*;

  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_CYCLES  = 32;
  localparam int HOLD_CYCLES   = 80;
  localparam int RANDOM_ITEMS  = 700;
  localparam int CALM_ITEMS    = 120;
  localparam int N_DIRECTED    = 32;

  typedef enum logic {KIND_CELL = 1'b0, KIND_DRAIN = 1'b1} item_kind_t;
  typedef enum bit {STEP_WRITE, STEP_ITEM} step_op_t;

  typedef struct packed {
    logic alive;
    logic last;
  } cave_result_t;

  typedef struct {
    step_op_t              op;
    cave_reg_t             reg_idx;
    logic [CFG_DATA_W-1:0] data;
    item_kind_t            kind;
    logic                  cell_bit;
    bit                    typed;   // outcome spelled out in the row
    bit                    yields;  // the item releases a result
    cave_result_t          want;
  } directed_step_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  cave_in_if  cells_ch ();
  cave_out_if gen_ch ();

  cave_automaton_step dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_s      (cells_ch),
    .out_s     (gen_ch),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // Register copies and automaton state of the predictor
  logic [SIZE_W-1:0] cfg_width   = RST_FRAME_WIDTH;
  logic [SIZE_W-1:0] cfg_height  = RST_FRAME_HEIGHT;
  logic [THR_W-1:0]  cfg_survive = RST_SURVIVE;
  logic [THR_W-1:0]  cfg_birth   = RST_BIRTH;
  bit                older_row [CAVE_MAX_WIDTH];
  bit                prior_row [CAVE_MAX_WIDTH];
  logic [8:0]        nbhd = '0;
  int                pos_col = 0;
  int                pos_row = 0;

  cave_result_t expected_cells [$];
  int           fail_count  = 0;
  int           cells_sent  = 0;
  bit           no_idle     = 1'b0;
  bit           hold_wanted = 1'b0;

  directed_step_t directed_steps [N_DIRECTED] = '{
    // 1x1 frame, both thresholds zero: a lone cell always comes out alive
    '{STEP_WRITE, REG_FRAME_WIDTH,  11'd0, KIND_CELL,  1'b0, 1'b0, 1'b0, 2'b00},
    '{STEP_WRITE, REG_FRAME_HEIGHT, 11'd0, KIND_CELL,  1'b0, 1'b0, 1'b0, 2'b00},
    '{STEP_WRITE, REG_SURVIVE,      11'd0, KIND_CELL,  1'b0, 1'b0, 1'b0, 2'b00},
    '{STEP_WRITE, REG_BIRTH,        11'd0, KIND_CELL,  1'b0, 1'b0, 1'b0, 2'b00},
    '{STEP_ITEM,  REG_FRAME_WIDTH,  11'd0, KIND_CELL,  1'b1, 1'b1, 1'b0, 2'b00},
    '{STEP_ITEM,  REG_FRAME_WIDTH,  11'd0, KIND_DRAIN, 1'b0, 1'b1, 1'b0, 2'b00},
    '{STEP_ITEM,  REG_FRAME_WIDTH,  11'd0, KIND_DRAIN, 1'b0, 1'b1, 1'b1, 2'b11},
    // drain in place of the only cell: a dead cell, born at threshold zero
    '{STEP_ITEM,  REG_FRAME_WIDTH,  11'd0, KIND_DRAIN, 1'b1, 1'b1, 1'b0, 2'b00},
    '{STEP_ITEM,  REG_FRAME_WIDTH,  11'd0, KIND_DRAIN, 1'b0, 1'b1, 1'b0, 2'b00},
    '{STEP_ITEM,  REG_FRAME_WIDTH,  11'd0, KIND_DRAIN, 1'b0, 1'b1, 1'b1, 2'b11},
    // thresholds above eight never hold; a live cell past the last row counts as drain
    '{STEP_WRITE, REG_SURVIVE,      11'd15, KIND_CELL, 1'b0, 1'b0, 1'b0, 2'b00},
    '{STEP_WRITE, REG_BIRTH,        11'd9,  KIND_CELL, 1'b0, 1'b0, 1'b0, 2'b00},
    '{STEP_ITEM,  REG_FRAME_WIDTH,  11'd0, KIND_CELL,  1'b1, 1'b1, 1'b0, 2'b00},
    '{STEP_ITEM,  REG_FRAME_WIDTH,  11'd0, KIND_CELL,  1'b1, 1'b1, 1'b0, 2'b00},
    '{STEP_ITEM,  REG_FRAME_WIDTH,  11'd0, KIND_DRAIN, 1'b0, 1'b1, 1'b1, 2'b01},
    // 3x3 frame of live cells at the stock thresholds
    '{STEP_WRITE, REG_FRAME_WIDTH,  11'd3, KIND_CELL,  1'b0, 1'b0, 1'b0, 2'b00},
    '{STEP_WRITE, REG_FRAME_HEIGHT, 11'd3, KIND_CELL,  1'b0, 1'b0, 1'b0, 2'b00},
    '{STEP_WRITE, REG_SURVIVE,      11'd4, KIND_CELL,  1'b0, 1'b0, 1'b0, 2'b00},
    '{STEP_WRITE, REG_BIRTH,        11'd5, KIND_CELL,  1'b0, 1'b0, 1'b0, 2'b00},
    '{STEP_ITEM,  REG_FRAME_WIDTH,  11'd0, KIND_CELL,  1'b1, 1'b0, 1'b0, 2'b00},
    '{STEP_ITEM,  REG_FRAME_WIDTH,  11'd0, KIND_CELL,  1'b1, 1'b0, 1'b0, 2'b00},
    '{STEP_ITEM,  REG_FRAME_WIDTH,  11'd0, KIND_CELL,  1'b1, 1'b0, 1'b0, 2'b00},
    '{STEP_ITEM,  REG_FRAME_WIDTH,  11'd0, KIND_CELL,  1'b1, 1'b0, 1'b0, 2'b00},
    '{STEP_ITEM,  REG_FRAME_WIDTH,  11'd0, KIND_CELL,  1'b1, 1'b0, 1'b0, 2'b00},
    '{STEP_ITEM,  REG_FRAME_WIDTH,  11'd0, KIND_CELL,  1'b1, 1'b0, 1'b0, 2'b00},
    '{STEP_ITEM,  REG_FRAME_WIDTH,  11'd0, KIND_CELL,  1'b1, 1'b0, 1'b0, 2'b00},
    '{STEP_ITEM,  REG_FRAME_WIDTH,  11'd0, KIND_CELL,  1'b1, 1'b0, 1'b0, 2'b00},
    '{STEP_ITEM,  REG_FRAME_WIDTH,  11'd0, KIND_CELL,  1'b1, 1'b0, 1'b0, 2'b00},
    '{STEP_ITEM,  REG_FRAME_WIDTH,  11'd0, KIND_DRAIN, 1'b0, 1'b0, 1'b0, 2'b00},
    '{STEP_ITEM,  REG_FRAME_WIDTH,  11'd0, KIND_DRAIN, 1'b0, 1'b0, 1'b0, 2'b00},
    '{STEP_ITEM,  REG_FRAME_WIDTH,  11'd0, KIND_DRAIN, 1'b0, 1'b0, 1'b0, 2'b00},
    '{STEP_ITEM,  REG_FRAME_WIDTH,  11'd0, KIND_DRAIN, 1'b0, 1'b0, 1'b0, 2'b00}
  };

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard limit on the run
  initial begin
    #2_000_000;
    $display("cave_automaton_step verification failed");
    $finish;
  end

  // Zero and oversized frame sizes fall back to the nearest legal size
  function automatic int clamp_dim(input logic [SIZE_W-1:0] v, input int cap);
    if (v == 0) return 1;
    if (v > cap) return cap;
    return v;
  endfunction

  // Survive or birth rule on the 8 cells around the window center
  function automatic logic cell_fate(input logic [8:0] win);
    int n;
    n = 0;
    for (int i = 0; i < 9; i++) begin
      if (i != 4) n += win[i];
    end
    return win[4] ? (n >= cfg_survive) : (n >= cfg_birth);
  endfunction

  // Advance the automaton by one item; returns 1 when a result is released
  function automatic bit next_generation_cell(input item_kind_t kind, input logic cell_bit,
                                              output cave_result_t res);
    int         w, h, r, c;
    logic       cur, top, mid;
    logic [2:0] column;
    bit         made, restart;
    w = clamp_dim(cfg_width, CAVE_MAX_WIDTH);
    h = clamp_dim(cfg_height, CAVE_MAX_HEIGHT);
    r = pos_row;
    c = pos_col;
    made = 1'b0;
    restart = 1'b0;
    res = '0;
    cur = (kind == KIND_CELL && r < h) ? cell_bit : 1'b0;
    top = 1'b0;
    mid = 1'b0;
    // shift the column through both line stores
    if (c < CAVE_MAX_WIDTH) begin
      top = (r >= 2) ? older_row[c] : 1'b0;
      mid = (r >= 1) ? prior_row[c] : 1'b0;
      older_row[c] = mid;
      prior_row[c] = cur;
    end
    column = {cur, mid, top};
    if (c == 0) begin
      // close the previous row's last cell against an empty right column
      nbhd = nbhd >> 3;
      if (r >= 2 && r - 2 < h) begin
        made = 1'b1;
        res.alive = cell_fate(nbhd);
        res.last = (r - 2 == h - 1);
      end
      restart = (r >= h + 1);
      nbhd = {column, 6'b0};
    end else begin
      nbhd = {column, nbhd[8:3]};
      if (r >= 1 && r - 1 < h) begin
        made = 1'b1;
        res.alive = cell_fate(nbhd);
        res.last = 1'b0;
      end
    end
    // advance the raster position
    if (restart) begin
      pos_row = 0;
      pos_col = 0;
      nbhd = '0;
    end else if (c + 1 >= w) begin
      pos_col = 0;
      pos_row = (r + 1) & 11'h7FF;
    end else begin
      pos_col = c + 1;
    end
    return made;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 11'd1;
      2: return 11'd2;
      3: return 11'($urandom_range(9, 16));
      default: return 11'($urandom_range(3, 8));
    endcase
  endfunction

  // Threshold in the low bits, junk above it
  function automatic logic [CFG_DATA_W-1:0] pick_threshold();
    logic [THR_W-1:0] thr;
    case ($urandom_range(0, 7))
      0: thr = '0;
      1: thr = 4'($urandom_range(9, 15));
      default: thr = 4'($urandom_range(1, 8));
    endcase
    return {7'($urandom), thr};
  endfunction

  // Offer one item and hold it until the transfer
  task automatic offer_item(input item_kind_t kind, input logic cell_bit);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      cells_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    cells_ch.valid   <= 1'b1;
    cells_ch.kind    <= kind;
    cells_ch.cell_in <= cell_bit;
    @(posedge clk);
    while (!cells_ch.ready) @(posedge clk);
    @(negedge clk);
    cells_sent++;
  endtask

  task automatic send_cell(input item_kind_t kind, input logic cell_bit);
    cave_result_t res;
    if (next_generation_cell(kind, cell_bit, res)) expected_cells.push_back(res);
    offer_item(kind, cell_bit);
  endtask

  // Write a register once every result is out and the pipeline has settled
  task automatic write_reg(input cave_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cells_ch.valid <= 1'b0;
    while (expected_cells.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_FRAME_WIDTH:  cfg_width   = data;
      REG_FRAME_HEIGHT: cfg_height  = data;
      REG_SURVIVE:      cfg_survive = data[THR_W-1:0];
      REG_BIRTH:        cfg_birth   = data[THR_W-1:0];
      default: ;
    endcase
  endtask

  // One frame of random cells, sometimes cut short, then drains until the frame closes
  task automatic play_frame(input bit may_cut);
    int full, cut, density;
    full = clamp_dim(cfg_width, CAVE_MAX_WIDTH) * clamp_dim(cfg_height, CAVE_MAX_HEIGHT);
    cut = (may_cut && $urandom_range(0, 7) == 0) ? $urandom_range(0, full) : full;
    case ($urandom_range(0, 4))
      0: density = 10;
      1: density = 90;
      default: density = $urandom_range(40, 60);
    endcase
    for (int i = 0; i < cut; i++) begin
      send_cell(($urandom_range(0, 19) == 0) ? KIND_DRAIN : KIND_CELL,
                $urandom_range(0, 99) < density);
    end
    while (pos_row != 0 || pos_col != 0) begin
      send_cell(($urandom_range(0, 3) == 0) ? KIND_CELL : KIND_DRAIN, 1'($urandom));
    end
  endtask

  // Result receiver: random stalls, one long hold on request
  initial begin
    int stall_left;
    stall_left = 0;
    gen_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
      end else if (hold_wanted) begin
        stall_left = HOLD_CYCLES;
        hold_wanted = 1'b0;
      end else if (!no_idle && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 3);
      end
      gen_ch.ready <= (stall_left == 0);
    end
  end

  // Compare each transfer with the oldest expected cell
  always @(posedge clk) begin
    cave_result_t want;
    if (rst_n && gen_ch.valid && gen_ch.ready) begin
      if (expected_cells.size() == 0) begin
        $error("unexpected result: cell_out=%0b last_out=%0b", gen_ch.cell_out,
               gen_ch.last_out);
        fail_count++;
      end else begin
        want = expected_cells.pop_front();
        if (gen_ch.cell_out !== want.alive) begin
          $error("cell_out: expected %0b, got %0b", want.alive, gen_ch.cell_out);
          fail_count++;
        end
        if (gen_ch.last_out !== want.last) begin
          $error("last_out: expected %0b, got %0b", want.last, gen_ch.last_out);
          fail_count++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    bit           made;
    cave_result_t res;
    int           base;
    rst_n            = 1'b0;
    cells_ch.valid   = 1'b0;
    cells_ch.kind    = KIND_CELL;
    cells_ch.cell_in = 1'b0;
    cfg_we           = 1'b0;
    cfg_addr         = REG_FRAME_WIDTH;
    cfg_wdata        = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // walk the directed table
    foreach (directed_steps[i]) begin
      if (directed_steps[i].op == STEP_WRITE) begin
        write_reg(directed_steps[i].reg_idx, directed_steps[i].data);
      end else begin
        made = next_generation_cell(directed_steps[i].kind, directed_steps[i].cell_bit, res);
        if (directed_steps[i].typed) begin
          if (directed_steps[i].yields) expected_cells.push_back(directed_steps[i].want);
        end else if (made) begin
          expected_cells.push_back(res);
        end
        offer_item(directed_steps[i].kind, directed_steps[i].cell_bit);
      end
    end

    // tall frame, one column wide, with the receiver held off long enough to back up
    write_reg(REG_FRAME_WIDTH, 11'd1);
    write_reg(REG_FRAME_HEIGHT, 11'd160);
    write_reg(REG_SURVIVE, pick_threshold());
    write_reg(REG_BIRTH, pick_threshold());
    hold_wanted = 1'b1;
    play_frame(1'b0);

    // zero height: a single row
    write_reg(REG_FRAME_WIDTH, 11'd24);
    write_reg(REG_FRAME_HEIGHT, 11'd0);
    play_frame(1'b0);

    // random frames, settings changed only between frames
    base = cells_sent;
    while (cells_sent - base < RANDOM_ITEMS) begin
      no_idle = (cells_sent - base >= RANDOM_ITEMS - CALM_ITEMS) || $urandom_range(0, 4) == 0;
      if ($urandom_range(0, 2) != 0) write_reg(REG_FRAME_WIDTH, pick_size());
      if ($urandom_range(0, 2) != 0) write_reg(REG_FRAME_HEIGHT, pick_size());
      if ($urandom_range(0, 2) != 0) write_reg(REG_SURVIVE, pick_threshold());
      if ($urandom_range(0, 2) != 0) write_reg(REG_BIRTH, pick_threshold());
      play_frame(1'b1);
    end

    // drop valid and wait out the last results
    cells_ch.valid <= 1'b0;
    while (expected_cells.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("cave_automaton_step verification clean");
    end else begin
      $display("cave_automaton_step verification failed");
    end
    $finish;
  end

endmodule
